// ===== design/jsu_pkg.sv =====
// jsu_pkg: shared types and codes for the JSON string unescaper
// request/response payloads, decoder state, mode enum, result and error codes
// no dependencies
`default_nettype none

package jsu_pkg;

   localparam int BURST_MAX = 4;
   localparam int CNT_W     = $clog2(BURST_MAX + 1);
   localparam int IDX_W     = $clog2(BURST_MAX);

   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [20:0]      cp_type;

   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_DONE  = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   localparam logic [2:0] ERR_CONTROL        = 3'd0;
   localparam logic [2:0] ERR_ESCAPE         = 3'd1;
   localparam logic [2:0] ERR_HEX            = 3'd2;
   localparam logic [2:0] ERR_LONE_HIGH      = 3'd3;
   localparam logic [2:0] ERR_BAD_LOW        = 3'd4;
   localparam logic [2:0] ERR_UNEXPECTED_LOW = 3'd5;
   localparam logic [2:0] ERR_UNTERMINATED   = 3'd6;
   localparam logic [2:0] ERR_INCOMPLETE     = 3'd7;

   localparam logic [7:0] CHR_QUOTE  = 8'h22;
   localparam logic [7:0] CHR_BSLASH = 8'h5C;
   localparam logic [7:0] CHR_SLASH  = 8'h2F;
   localparam logic [7:0] CHR_U      = 8'h75;
   localparam logic [7:0] CHR_SPACE  = 8'h20;

   localparam logic [5:0] SURR_HIGH_TOP = 6'b110110;
   localparam logic [5:0] SURR_LOW_TOP  = 6'b110111;
   localparam cp_type     SUPP_BASE     = 21'h10000;

   typedef enum logic [6:0] {
      MODE_BODY      = 7'b0000001,
      MODE_ESC       = 7'b0000010,
      MODE_HEX_FIRST = 7'b0000100,
      MODE_LOW_BS    = 7'b0001000,
      MODE_LOW_U     = 7'b0010000,
      MODE_HEX_LOW   = 7'b0100000,
      MODE_IDLE      = 7'b1000000
   } mode_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] out_byte;
      logic [2:0] error_code;
      logic       last_of_run;
   } rsp_type;

   typedef rsp_type [BURST_MAX-1:0] burst_type;

   typedef struct packed {
      mode_type    mode;
      logic [1:0]  hex_cnt;
      logic [15:0] acc;
      logic [9:0]  high_bits;
   } state_type;

endpackage

`default_nettype wire

// ===== design/jsu_decode.sv =====
// jsu_decode: combinational step of the unescaper, one source byte per call
// gives next decoder state and the burst of up to four responses with its count
// depends on jsu_pkg
`default_nettype none

module jsu_decode (
   input  jsu_pkg::state_type st,
   input  jsu_pkg::req_type   req,
   output jsu_pkg::state_type st_nxt,
   output jsu_pkg::burst_type burst,
   output jsu_pkg::cnt_type   burst_cnt
);
   import jsu_pkg::*;

   logic [7:0]          c;
   logic                hex_ok;
   logic [3:0]          hex_val;
   logic [15:0]         quad;
   logic                is_low;
   logic                is_high;
   cp_type              pair_cp;
   logic                esc_ok;
   logic [7:0]          esc_byte;
   logic                fire_err;
   logic [2:0]          err_code;
   logic                fire_done;
   logic                fire_byte;
   logic [7:0]          byte_val;
   logic                fire_utf;
   cp_type              utf_cp;
   logic [3:0][7:0]     utf_bytes;
   cnt_type             utf_n;

   assign c       = req.in_byte;
   assign quad    = {st.acc[11:0], hex_val};
   assign is_low  = (quad[15:10] == SURR_LOW_TOP);
   assign is_high = (quad[15:10] == SURR_HIGH_TOP);
   assign pair_cp = {1'b0, st.high_bits, quad[9:0]} + SUPP_BASE;

   always_comb begin
      hex_ok  = 1'b1;
      hex_val = c[3:0];
      case (c) inside
         [8'h30:8'h39]: hex_val = c[3:0];
         [8'h41:8'h46], [8'h61:8'h66]: hex_val = c[3:0] + 4'd9;
         default: begin
            hex_ok  = 1'b0;
            hex_val = 4'd0;
         end
      endcase
   end

   always_comb begin
      esc_ok = 1'b1;
      case (c)
         CHR_QUOTE:  esc_byte = CHR_QUOTE;
         CHR_BSLASH: esc_byte = CHR_BSLASH;
         CHR_SLASH:  esc_byte = CHR_SLASH;
         8'h62:      esc_byte = 8'h08;
         8'h66:      esc_byte = 8'h0C;
         8'h6E:      esc_byte = 8'h0A;
         8'h72:      esc_byte = 8'h0D;
         8'h74:      esc_byte = 8'h09;
         default: begin
            esc_ok   = 1'b0;
            esc_byte = 8'h00;
         end
      endcase
   end

   always_comb begin
      st_nxt    = st;
      fire_err  = 1'b0;
      err_code  = ERR_CONTROL;
      fire_done = 1'b0;
      fire_byte = 1'b0;
      byte_val  = c;
      fire_utf  = 1'b0;
      utf_cp    = '0;
      if (req.end_of_input) begin
         case (st.mode)
            MODE_BODY: begin
               fire_err = 1'b1;
               err_code = ERR_UNTERMINATED;
            end
            MODE_ESC, MODE_HEX_FIRST, MODE_HEX_LOW: begin
               fire_err = 1'b1;
               err_code = ERR_INCOMPLETE;
            end
            MODE_LOW_BS, MODE_LOW_U: begin
               fire_err = 1'b1;
               err_code = ERR_LONE_HIGH;
            end
            default: ;
         endcase
         st_nxt.mode = MODE_IDLE;
      end else begin
         case (st.mode)
            MODE_BODY: begin
               if (c == CHR_QUOTE) begin
                  fire_done   = 1'b1;
                  st_nxt.mode = MODE_IDLE;
               end else if (c < CHR_SPACE) begin
                  fire_err    = 1'b1;
                  err_code    = ERR_CONTROL;
                  st_nxt.mode = MODE_IDLE;
               end else if (c == CHR_BSLASH) begin
                  st_nxt.mode = MODE_ESC;
               end else begin
                  fire_byte = 1'b1;
               end
            end
            MODE_ESC: begin
               if (c == CHR_U) begin
                  st_nxt.mode    = MODE_HEX_FIRST;
                  st_nxt.hex_cnt = 2'd0;
                  st_nxt.acc     = 16'd0;
               end else if (esc_ok) begin
                  fire_byte   = 1'b1;
                  byte_val    = esc_byte;
                  st_nxt.mode = MODE_BODY;
               end else begin
                  fire_err    = 1'b1;
                  err_code    = ERR_ESCAPE;
                  st_nxt.mode = MODE_IDLE;
               end
            end
            MODE_HEX_FIRST, MODE_HEX_LOW: begin
               if (!hex_ok) begin
                  fire_err    = 1'b1;
                  err_code    = ERR_HEX;
                  st_nxt.mode = MODE_IDLE;
               end else if (st.hex_cnt != 2'd3) begin
                  st_nxt.acc     = quad;
                  st_nxt.hex_cnt = st.hex_cnt + 2'd1;
               end else begin
                  st_nxt.hex_cnt = 2'd0;
                  st_nxt.acc     = 16'd0;
                  if (st.mode == MODE_HEX_FIRST) begin
                     if (is_low) begin
                        fire_err    = 1'b1;
                        err_code    = ERR_UNEXPECTED_LOW;
                        st_nxt.mode = MODE_IDLE;
                     end else if (is_high) begin
                        st_nxt.high_bits = quad[9:0];
                        st_nxt.mode      = MODE_LOW_BS;
                     end else begin
                        fire_utf    = 1'b1;
                        utf_cp      = {5'd0, quad};
                        st_nxt.mode = MODE_BODY;
                     end
                  end else if (!is_low) begin
                     fire_err    = 1'b1;
                     err_code    = ERR_BAD_LOW;
                     st_nxt.mode = MODE_IDLE;
                  end else begin
                     fire_utf    = 1'b1;
                     utf_cp      = pair_cp;
                     st_nxt.mode = MODE_BODY;
                  end
               end
            end
            MODE_LOW_BS: begin
               if (c == CHR_BSLASH) begin
                  st_nxt.mode = MODE_LOW_U;
               end else begin
                  fire_err    = 1'b1;
                  err_code    = ERR_LONE_HIGH;
                  st_nxt.mode = MODE_IDLE;
               end
            end
            MODE_LOW_U: begin
               if (c == CHR_U) begin
                  st_nxt.mode    = MODE_HEX_LOW;
                  st_nxt.hex_cnt = 2'd0;
                  st_nxt.acc     = 16'd0;
               end else begin
                  fire_err    = 1'b1;
                  err_code    = ERR_LONE_HIGH;
                  st_nxt.mode = MODE_IDLE;
               end
            end
            default: begin
               st_nxt.mode = (c == CHR_QUOTE) ? MODE_BODY : MODE_IDLE;
            end
         endcase
      end
   end

   // utf-8 encoding of the code point
   always_comb begin
      utf_bytes = '0;
      if (utf_cp <= 21'h7F) begin
         utf_bytes[0] = utf_cp[7:0];
         utf_n        = cnt_type'(1);
      end else if (utf_cp <= 21'h7FF) begin
         utf_bytes[0] = {3'b110, utf_cp[10:6]};
         utf_bytes[1] = {2'b10, utf_cp[5:0]};
         utf_n        = cnt_type'(2);
      end else if (utf_cp <= 21'hFFFF) begin
         utf_bytes[0] = {4'b1110, utf_cp[15:12]};
         utf_bytes[1] = {2'b10, utf_cp[11:6]};
         utf_bytes[2] = {2'b10, utf_cp[5:0]};
         utf_n        = cnt_type'(3);
      end else begin
         utf_bytes[0] = {5'b11110, utf_cp[20:18]};
         utf_bytes[1] = {2'b10, utf_cp[17:12]};
         utf_bytes[2] = {2'b10, utf_cp[11:6]};
         utf_bytes[3] = {2'b10, utf_cp[5:0]};
         utf_n        = cnt_type'(4);
      end
   end

   always_comb begin
      burst     = '0;
      burst_cnt = '0;
      if (fire_err) begin
         burst[0].kind       = KIND_ERROR;
         burst[0].error_code = err_code;
         burst_cnt           = cnt_type'(1);
      end else if (fire_done) begin
         burst[0].kind = KIND_DONE;
         burst_cnt     = cnt_type'(1);
      end else if (fire_byte) begin
         burst[0].kind     = KIND_DATA;
         burst[0].out_byte = byte_val;
         burst_cnt         = cnt_type'(1);
      end else if (fire_utf) begin
         for (int i = 0; i < BURST_MAX; i++) begin
            burst[i].kind     = KIND_DATA;
            burst[i].out_byte = utf_bytes[i];
         end
         burst_cnt = utf_n;
      end
      for (int i = 0; i < BURST_MAX; i++) begin
         burst[i].last_of_run = (cnt_type'(i + 1) == burst_cnt);
      end
   end

endmodule

`default_nettype wire

// ===== design/json_string_unescape_utf8_unit.sv =====
// Unescapes a JSON string body to UTF-8, one source byte per request, and
// reports completion or errors; each request yields zero to four responses,
// the last of them marked by last_of_run. A request is taken every cycle that
// req_ready is high into an input register, decoded in one step, and its
// responses are loaded into a four-entry burst register that hands out one
// response per cycle while rsp_ready is high. A request that yields responses
// leaves the input register only once the burst register is empty or its
// last response is being taken, so the burst register's drain rate of one
// response per cycle sets the throughput, while requests that yield nothing
// pass without waiting.
// Depends on jsu_pkg and jsu_decode.
`default_nettype none

module json_string_unescape_utf8_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  jsu_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output jsu_pkg::rsp_type rsp_payload
);
   import jsu_pkg::*;

   logic      in_vld_ff;
   logic      in_vld_in;
   req_type   in_ff;
   state_type st_ff;
   state_type st_in;
   burst_type bst_ff;
   cnt_type   bst_cnt_ff;
   cnt_type   bst_cnt_in;
   idx_type   bst_idx_ff;
   idx_type   bst_idx_in;

   state_type dec_st;
   burst_type dec_burst;
   cnt_type   dec_cnt;

   logic drain;
   logic bst_free;
   logic advance;
   logic load;

   jsu_decode u_decode (
      .st        (st_ff),
      .req       (in_ff),
      .st_nxt    (dec_st),
      .burst     (dec_burst),
      .burst_cnt (dec_cnt)
   );

   assign rsp_valid   = (bst_cnt_ff != '0);
   assign rsp_payload = bst_ff[bst_idx_ff];
   assign drain       = rsp_valid && rsp_ready;
   assign bst_free    = (bst_cnt_ff == '0) || ((bst_cnt_ff == cnt_type'(1)) && drain);
   assign advance     = in_vld_ff && ((dec_cnt == '0) || bst_free);
   assign load        = advance && (dec_cnt != '0);
   assign req_ready   = !in_vld_ff || advance;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_valid && req_ready) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
   end

   assign st_in = advance ? dec_st : st_ff;

   always_comb begin
      bst_cnt_in = bst_cnt_ff;
      bst_idx_in = bst_idx_ff;
      if (load) begin
         bst_cnt_in = dec_cnt;
         bst_idx_in = '0;
      end else if (drain) begin
         bst_cnt_in = bst_cnt_ff - cnt_type'(1);
         bst_idx_in = bst_idx_ff + idx_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff          <= 1'b0;
         st_ff.mode         <= MODE_BODY;
         st_ff.hex_cnt      <= 2'd0;
         st_ff.acc          <= 16'd0;
         st_ff.high_bits    <= 10'd0;
         bst_cnt_ff         <= '0;
         bst_idx_ff         <= '0;
      end else begin
         in_vld_ff  <= in_vld_in;
         st_ff      <= st_in;
         bst_cnt_ff <= bst_cnt_in;
         bst_idx_ff <= bst_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_payload;
      end
      if (load) begin
         bst_ff <= dec_burst;
      end
   end

`ifndef SYNTHESIS
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid)
      else $error("burst load did not produce a response");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      bst_cnt_ff <= cnt_type'(BURST_MAX))
      else $error("burst count out of range");

   a_last_marked: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (bst_cnt_ff == cnt_type'(1))) |-> rsp_payload.last_of_run)
      else $error("final response of a burst lacks last_of_run");

   a_mid_unmarked: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (bst_cnt_ff > cnt_type'(1))) |-> !rsp_payload.last_of_run)
      else $error("last_of_run set before end of burst");

   a_hold_request: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && !advance) |=> (in_vld_ff && $stable(in_ff)))
      else $error("stalled request lost from input register");
`endif

endmodule

`default_nettype wire
